/* hw/rtl/i2cbm_pkg.sv */
// Package for the I2C bit-level master: command kinds, pin actions and the
// step decode shared by the engine. No dependencies.

package i2cbm_pkg;

   localparam logic [2:0] KIND_TICK  = 3'd0;
   localparam logic [2:0] KIND_START = 3'd1;
   localparam logic [2:0] KIND_STOP  = 3'd2;
   localparam logic [2:0] KIND_TX    = 3'd3;
   localparam logic [2:0] KIND_RX    = 3'd4;
   localparam logic [2:0] KIND_SACK  = 3'd5;
   localparam logic [2:0] KIND_RACK  = 3'd6;

   localparam logic [15:0] PHASE_RESET = 16'd10;

   typedef enum logic [2:0] {
      ACT_SCL0,
      ACT_SCL1,
      ACT_SDA0,
      ACT_SDA1,
      ACT_READ
   } act_type;

   function automatic logic [4:0] op_steps(logic [2:0] op);
      logic [4:0] n;
      unique case (op)
         KIND_START: n = 5'd4;
         KIND_STOP:  n = 5'd3;
         KIND_TX:    n = 5'd24;
         KIND_RX:    n = 5'd25;
         KIND_SACK:  n = 5'd3;
         KIND_RACK:  n = 5'd4;
         default:    n = 5'd0;
      endcase
      return n;
   endfunction

   // t / 3 as (t * 11) >> 5, exact for t below 24
   function automatic act_type step_action(logic [2:0] op, logic [4:0] s,
                                           logic [7:0] shift, logic sack);
      logic [4:0] t;
      logic [8:0] prod;
      logic [2:0] bitn;
      logic [4:0] ph_w;
      logic [1:0] ph;
      act_type    a;
      t    = (op == KIND_RX) ? s - 5'd1 : s;
      prod = 9'(t) * 9'd11;
      bitn = prod[7:5];
      ph_w = t - (5'({bitn, 1'b0}) + 5'(bitn));
      ph   = ph_w[1:0];
      unique case (op)
         KIND_START: begin
            unique case (s[1:0])
               2'd0:    a = ACT_SDA1;
               2'd1:    a = ACT_SCL1;
               2'd2:    a = ACT_SDA0;
               default: a = ACT_SCL0;
            endcase
         end
         KIND_STOP: begin
            if (s == 5'd0) a = ACT_SDA0;
            else if (s == 5'd1) a = ACT_SCL1;
            else a = ACT_SDA1;
         end
         KIND_TX: begin
            if (ph == 2'd0) a = shift[3'd7 - bitn] ? ACT_SDA1 : ACT_SDA0;
            else if (ph == 2'd1) a = ACT_SCL1;
            else a = ACT_SCL0;
         end
         KIND_RX: begin
            if (s == 5'd0) a = ACT_SDA1;
            else if (ph == 2'd0) a = ACT_SCL1;
            else if (ph == 2'd1) a = ACT_READ;
            else a = ACT_SCL0;
         end
         KIND_SACK: begin
            if (s == 5'd0) a = sack ? ACT_SDA1 : ACT_SDA0;
            else if (s == 5'd1) a = ACT_SCL1;
            else a = ACT_SCL0;
         end
         KIND_RACK: begin
            unique case (s[1:0])
               2'd0:    a = ACT_SDA1;
               2'd1:    a = ACT_SCL1;
               2'd2:    a = ACT_READ;
               default: a = ACT_SCL0;
            endcase
         end
         default: a = ACT_READ;
      endcase
      return a;
   endfunction

endpackage

/* hw/rtl/i2c_bit_level_master.sv */
// I2C bit-level master: top level, the whole engine in one module.
// Depends on i2cbm_pkg.
//
// Usage:
//  req channel: tuser carries the kind (tick, start, stop, send byte,
//  receive byte, send ack, receive ack); tdata carries tx_byte, ack_bit and
//  the sampled SDA level. A command starts a primitive when idle; ticks
//  advance it, each pin step lasting phase_length ticks. A command while
//  busy is dropped and flagged as rejected.
//  rsp channel: one response per request with the pin drives, busy, done,
//  last received byte, last acknowledge seen and the rejected flag.
//  csr channel: writes phase_length (zero counts as one); always ready,
//  to be written only while idle.
//  Timing: response valid in the cycle after the request is taken. Throughput
//  one request per cycle while rsp is not stalled, set by the single state update
//  between the input handshake and the response register.
//  Reset: pins released high, engine idle, phase_length 10, no response.
//  Stall: while rsp_tready is low with a response waiting, req_tready drops
//  and the response register holds.

module i2c_bit_level_master (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // [2:0] kind
   input  logic [15:0] req_tdata,   // [7:0] tx_byte, [8] ack_bit, [9] sda_in, rest zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res, [11:4] rx_byte,
   // [12] ack_seen, [13] rejected, rest zero
   output logic [15:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);
   import i2cbm_pkg::*;

   logic [15:0] phase_ff;
   logic [2:0]  op_ff, op_in;
   logic [4:0]  step_ff, step_in;
   logic [15:0] tick_ff, tick_in;
   logic [7:0]  shift_ff, shift_in;
   logic        sack_ff, sack_in;
   logic        scl_level_ff, scl_level_in;
   logic        sda_level_ff, sda_level_in;
   logic [7:0]  rbyte_ff, rbyte_in;
   logic        rack_ff, rack_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_data_ff, rsp_data_in;

   logic        accept;
   logic [2:0]  kind;
   logic        req_sda;
   logic [15:0] limit;
   logic [16:0] tc_inc;
   logic [4:0]  step_inc;
   act_type     cur_act;
   act_type     apply_act;
   logic        apply_en;
   logic        done;
   logic        rej;

   assign kind       = req_tuser;
   assign req_sda    = req_tdata[9];
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign limit    = (phase_ff == 16'd0) ? 16'd1 : phase_ff;
   assign tc_inc   = {1'b0, tick_ff} + 17'd1;
   assign step_inc = step_ff + 5'd1;
   assign cur_act  = step_action(op_ff, step_ff, shift_ff, sack_ff);

   always_comb begin
      op_in        = op_ff;
      step_in      = step_ff;
      tick_in      = tick_ff;
      shift_in     = shift_ff;
      sack_in      = sack_ff;
      rbyte_in     = rbyte_ff;
      rack_in      = rack_ff;
      scl_level_in = scl_level_ff;
      sda_level_in = sda_level_ff;
      apply_en     = 1'b0;
      apply_act    = ACT_READ;
      done         = 1'b0;
      rej          = 1'b0;
      if (kind == KIND_TICK) begin
         if (op_ff != KIND_TICK) begin
            if (tick_ff == 16'd0 && cur_act == ACT_READ) begin
               if (op_ff == KIND_RX) shift_in = {shift_ff[6:0], req_sda};
               else rack_in = req_sda;
            end
            if (tc_inc >= {1'b0, limit}) begin
               tick_in = 16'd0;
               step_in = step_inc;
               if (step_inc >= op_steps(op_ff)) begin
                  if (op_ff == KIND_RX) rbyte_in = shift_in;
                  op_in   = KIND_TICK;
                  step_in = 5'd0;
                  done    = 1'b1;
               end else begin
                  apply_en  = 1'b1;
                  apply_act = step_action(op_ff, step_inc, shift_in, sack_ff);
               end
            end else begin
               tick_in = tc_inc[15:0];
            end
         end
      end else if (kind <= KIND_RACK) begin
         if (op_ff != KIND_TICK) begin
            rej = 1'b1;
         end else begin
            op_in   = kind;
            step_in = 5'd0;
            tick_in = 16'd0;
            if (kind == KIND_TX) shift_in = req_tdata[7:0];
            else if (kind == KIND_RX) shift_in = 8'd0;
            if (kind == KIND_SACK) sack_in = req_tdata[8];
            apply_en  = 1'b1;
            apply_act = step_action(kind, 5'd0, shift_in, sack_in);
         end
      end
      if (apply_en) begin
         unique case (apply_act)
            ACT_SCL0: scl_level_in = 1'b0;
            ACT_SCL1: scl_level_in = 1'b1;
            ACT_SDA0: sda_level_in = 1'b0;
            ACT_SDA1: sda_level_in = 1'b1;
            default: ;
         endcase
      end
      rsp_data_in  = {2'b00, rej, rack_in, rbyte_in, done, (op_in != KIND_TICK),
                      sda_level_in, scl_level_in};
      rsp_valid_in = accept ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_RESET;
         op_ff        <= KIND_TICK;
         step_ff      <= 5'd0;
         tick_ff      <= 16'd0;
         shift_ff     <= 8'd0;
         sack_ff      <= 1'b0;
         scl_level_ff <= 1'b1;
         sda_level_ff <= 1'b1;
         rbyte_ff     <= 8'd0;
         rack_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) phase_ff <= csr_data;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            op_ff        <= op_in;
            step_ff      <= step_in;
            tick_ff      <= tick_in;
            shift_ff     <= shift_in;
            sack_ff      <= sack_in;
            scl_level_ff <= scl_level_in;
            sda_level_ff <= sda_level_in;
            rbyte_ff     <= rbyte_in;
            rack_ff      <= rack_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) rsp_data_ff <= rsp_data_in;
   end

   // checks
   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      (op_ff != KIND_TICK) |-> (step_ff < op_steps(op_ff)))
      else $error("step index beyond primitive length");

   a_tick_below_limit: assert property (@(posedge clock) disable iff (reset)
      (op_ff != KIND_TICK) |-> (tick_ff < limit))
      else $error("tick count reached phase limit while busy");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (op_ff == KIND_TICK) |-> (step_ff == 5'd0 && tick_ff == 16'd0))
      else $error("idle engine holds step or tick state");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[3]) |-> (!rsp_data_ff[2] && !rsp_data_ff[13]))
      else $error("done reported with busy or rejected");

   a_reject_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[13]) |-> rsp_data_ff[2])
      else $error("rejection reported while idle");

endmodule
